// File: sv/thermal_derate_tilt_cutoff_macros.svh
// Assertion helpers shared by the thermal derate / tilt cutoff RTL
`ifndef THERMAL_DERATE_TILT_CUTOFF_MACROS_SVH
`define THERMAL_DERATE_TILT_CUTOFF_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TDTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TDTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tdtc_pkg.sv
`timescale 1ns / 1ps
package tdtc_pkg;

   // Field widths
   localparam int TEMP_W  = 13;
   localparam int TILT_W  = 13;
   localparam int LIM_W   = 12;
   localparam int PWM_W   = 8;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 13;
   localparam int IDX_W   = 3;

   // Divider: dividend is at most 8b x 13b, quotient never exceeds the mode maximum
   localparam int DIVD_W  = PWM_W + TEMP_W;
   localparam int DIVS_W  = TEMP_W;

   // Rule constants
   localparam logic                THERMAL_ENABLE = 1'b1;
   localparam logic                TILT_ENABLE    = 1'b1;
   localparam logic [TIME_W-1:0]   TRIP_DELAY_MS  = 32'd2000;
   localparam logic signed [TEMP_W:0] HYST_UNITS  = 14'sd32;
   localparam logic [PWM_W-1:0]    DRIVE_FLOOR    = 8'd20;
   localparam logic [DIVS_W-1:0]   FACTOR_MIN_DIV = 13'd20;

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_TEMP_MAX      = 3'd0,
      REG_TEMP_CRIT     = 3'd1,
      REG_PWM_NORMAL    = 3'd2,
      REG_PWM_SAVING    = 3'd3,
      REG_TILT_FORWARD  = 3'd4,
      REG_TILT_BACKWARD = 3'd5,
      REG_TILT_RIGHT    = 3'd6,
      REG_TILT_LEFT     = 3'd7
   } reg_idx_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PREP = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   // Thermal rule outcome for one check
   typedef enum logic [1:0] {
      TH_HOLD,
      TH_CUT,
      TH_DERATE,
      TH_RECOVER
   } thermal_type;

endpackage

// File: sv/thermal_derate_tilt_cutoff.sv
`timescale 1ns / 1ps
// A check outside the derate band goes from PREP to FIN and then to the result register;
// inside it, PREP forms the product and the compare/subtract divider runs 8 restoring-divide steps in DIV.
// A new check is accepted only in IDLE, after the earlier one has left FIN for the result register.
// A new check is taken while an earlier result still waits on the result channel.
// Reset (synchronous, active high) loads default limits and clears target, latch and timer.
`include "thermal_derate_tilt_cutoff_macros.svh"
module thermal_derate_tilt_cutoff (
   input  logic                              clock,
   input  logic                              reset,
   // check input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tdtc_pkg::TIME_W-1:0]       req_time_ms,
   input  logic signed [tdtc_pkg::TEMP_W-1:0] req_temperature,
   input  logic                              req_power_on,
   input  logic                              req_power_saving,
   input  logic signed [tdtc_pkg::TILT_W-1:0] req_tilt_x,
   input  logic signed [tdtc_pkg::TILT_W-1:0] req_tilt_y,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tdtc_pkg::PWM_W-1:0]        rsp_drive_target,
   output logic                              rsp_tilt_tripped,
   // register writes
   input  logic                              csr_we,
   input  logic [tdtc_pkg::IDX_W-1:0]        csr_index,
   input  logic [tdtc_pkg::CSR_W-1:0]        csr_wdata
);
   import tdtc_pkg::*;

   // Configuration registers
   logic signed [TEMP_W-1:0] cut_temp_ff, temp_crit_ff;
   logic [PWM_W-1:0]         pwm_normal_ff, pwm_saving_ff;
   logic [LIM_W-1:0]         tilt_fwd_ff, tilt_bwd_ff, tilt_right_ff, tilt_left_ff;

   // Held check
   logic [TIME_W-1:0]        in_time_ff;
   logic signed [TEMP_W-1:0] in_temp_ff;
   logic                     in_power_ff, in_saving_ff;
   logic signed [TILT_W-1:0] in_tx_ff, in_ty_ff;

   // Safety state
   logic [PWM_W-1:0]  pwm_target_ff, pwm_target_in;
   logic              latched_ff, latched_in;
   logic              timing_ff, timing_in;
   logic [TIME_W-1:0] begin_ff, begin_in;

   // Sequencer and divider
   state_type         state_ff, state_in;
   logic [2:0]        cnt_ff;
   logic [DIVD_W-1:0] rem_ff;
   logic [DIVD_W-1:0] dsh_ff;
   logic [PWM_W-1:0]  quo_ff;

   // Result register
   logic              rsp_valid_ff;
   logic [PWM_W-1:0]  rsp_target_ff;
   logic              rsp_tripped_ff;

   logic                     in_xfer, out_free, commit;
   logic [PWM_W-1:0]         mode_max;
   logic signed [TEMP_W:0]   temp_ext, max_ext, crit_ext, crit_lo, range_s, left_s;
   logic [DIVS_W-1:0]        range_u, left_u;
   logic [17:0]              left_x20;
   logic                     min_hit;
   logic [DIVD_W-1:0]        prod;
   thermal_type              th_branch;
   logic signed [TILT_W:0]   tx_ext, ty_ext, lim_fwd, lim_bwd, lim_right, lim_left;
   logic                     tilted;
   logic [TIME_W-1:0]        begin_sel, elapsed;
   logic [PWM_W-1:0]         derated;
   logic                     rem_ge;

   assign req_ready = (state_ff == S_IDLE);
   assign in_xfer   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == S_FIN) && out_free;

   // Operand setup for the thermal rule
   assign mode_max = in_saving_ff ? pwm_saving_ff : pwm_normal_ff;
   assign temp_ext = {in_temp_ff[TEMP_W-1], in_temp_ff};
   assign max_ext  = {cut_temp_ff[TEMP_W-1], cut_temp_ff};
   assign crit_ext = {temp_crit_ff[TEMP_W-1], temp_crit_ff};
   assign crit_lo  = crit_ext - HYST_UNITS;
   assign range_s  = max_ext - crit_ext;
   assign left_s   = max_ext - temp_ext;
   assign range_u  = range_s[DIVS_W-1:0];
   assign left_u   = left_s[DIVS_W-1:0];
   assign left_x20 = {1'b0, left_u, 4'b0000} + {3'b000, left_u, 2'b00};
   assign min_hit  = left_x20 < {5'b00000, range_u};
   assign prod     = {{(DIVD_W-PWM_W){1'b0}}, mode_max} * {{(DIVD_W-DIVS_W){1'b0}}, left_u};

   // Classify temperature against the limits
   always_comb begin
      if (temp_ext >= max_ext) begin
         th_branch = TH_CUT;
      end else if (temp_ext > crit_ext) begin
         th_branch = TH_DERATE;
      end else if (temp_ext < crit_lo) begin
         th_branch = TH_RECOVER;
      end else begin
         th_branch = TH_HOLD;
      end
   end

   // Tilt limit checks
   assign tx_ext    = {in_tx_ff[TILT_W-1], in_tx_ff};
   assign ty_ext    = {in_ty_ff[TILT_W-1], in_ty_ff};
   assign lim_fwd   = $signed({2'b00, tilt_fwd_ff});
   assign lim_right = $signed({2'b00, tilt_right_ff});
   assign lim_bwd   = -$signed({2'b00, tilt_bwd_ff});
   assign lim_left  = -$signed({2'b00, tilt_left_ff});
   assign tilted    = (tx_ext > lim_fwd) || (tx_ext < lim_bwd) ||
                      (ty_ext > lim_right) || (ty_ext < lim_left);
   assign begin_sel = timing_ff ? begin_ff : in_time_ff;
   assign elapsed   = in_time_ff - begin_sel;

   // Shared divider step
   assign rem_ge  = rem_ff >= dsh_ff;
   assign derated = (quo_ff < DRIVE_FLOOR) ? DRIVE_FLOOR : quo_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (in_xfer) state_in = S_PREP;
         S_PREP: state_in = (in_power_ff && th_branch == TH_DERATE) ? S_DIV : S_FIN;
         S_DIV:  if (cnt_ff == 3'd7) state_in = S_FIN;
         S_FIN:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Apply thermal and tilt rules to the state
   always_comb begin
      pwm_target_in = pwm_target_ff;
      latched_in    = latched_ff;
      timing_in     = timing_ff;
      begin_in      = begin_ff;
      if (in_power_ff) begin
         if (THERMAL_ENABLE) begin
            case (th_branch)
               TH_CUT:     pwm_target_in = '0;
               TH_DERATE:  pwm_target_in = derated;
               TH_RECOVER: pwm_target_in = mode_max;
               default:    pwm_target_in = pwm_target_ff;
            endcase
            if (latched_ff) pwm_target_in = '0;
         end
         if (TILT_ENABLE && !(THERMAL_ENABLE && th_branch == TH_CUT)) begin
            if (tilted && !latched_ff) begin
               begin_in  = begin_sel;
               timing_in = 1'b1;
               if (elapsed >= TRIP_DELAY_MS) begin
                  latched_in    = 1'b1;
                  pwm_target_in = '0;
               end
            end else if (!tilted) begin
               timing_in = 1'b0;
               if (latched_ff) begin
                  latched_in = 1'b0;
                  if (!THERMAL_ENABLE || temp_ext < crit_ext) pwm_target_in = mode_max;
               end
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pwm_target_ff <= '0;
         latched_ff    <= 1'b0;
         timing_ff     <= 1'b0;
         begin_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff  <= 1'b1;
            pwm_target_ff <= pwm_target_in;
            latched_ff    <= latched_in;
            timing_ff     <= timing_in;
            begin_ff      <= begin_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_temp_ff   <= 13'sd1280;
         temp_crit_ff  <= 13'sd1120;
         pwm_normal_ff <= 8'd255;
         pwm_saving_ff <= 8'd128;
         tilt_fwd_ff   <= 12'd480;
         tilt_bwd_ff   <= 12'd480;
         tilt_right_ff <= 12'd480;
         tilt_left_ff  <= 12'd480;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_TEMP_MAX:      cut_temp_ff   <= $signed(csr_wdata);
            REG_TEMP_CRIT:     temp_crit_ff  <= $signed(csr_wdata);
            REG_PWM_NORMAL:    pwm_normal_ff <= csr_wdata[PWM_W-1:0];
            REG_PWM_SAVING:    pwm_saving_ff <= csr_wdata[PWM_W-1:0];
            REG_TILT_FORWARD:  tilt_fwd_ff   <= csr_wdata[LIM_W-1:0];
            REG_TILT_BACKWARD: tilt_bwd_ff   <= csr_wdata[LIM_W-1:0];
            REG_TILT_RIGHT:    tilt_right_ff <= csr_wdata[LIM_W-1:0];
            REG_TILT_LEFT:     tilt_left_ff  <= csr_wdata[LIM_W-1:0];
            default:           ;
         endcase
      end
   end

   // Hold the check, run the divider, load the result
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         in_time_ff   <= req_time_ms;
         in_temp_ff   <= req_temperature;
         in_power_ff  <= req_power_on;
         in_saving_ff <= req_power_saving;
         in_tx_ff     <= req_tilt_x;
         in_ty_ff     <= req_tilt_y;
      end
      if (state_ff == S_PREP) begin
         cnt_ff <= '0;
         quo_ff <= '0;
         if (min_hit) begin
            rem_ff <= {{(DIVD_W-PWM_W){1'b0}}, mode_max};
            dsh_ff <= {1'b0, FACTOR_MIN_DIV, 7'd0};
         end else begin
            rem_ff <= prod;
            dsh_ff <= {1'b0, range_u, 7'd0};
         end
      end else if (state_ff == S_DIV) begin
         cnt_ff <= cnt_ff + 3'd1;
         quo_ff <= {quo_ff[PWM_W-2:0], rem_ge};
         if (rem_ge) rem_ff <= rem_ff - dsh_ff;
         dsh_ff <= {1'b0, dsh_ff[DIVD_W-1:1]};
      end
      if (commit) begin
         rsp_target_ff  <= pwm_target_in;
         rsp_tripped_ff <= latched_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_target = rsp_target_ff;
   assign rsp_tilt_tripped = rsp_tripped_ff;

   // Checks
   `TDTC_ASSERT_NOW(a_latched_zero, clock, reset, rsp_valid && rsp_tilt_tripped, rsp_drive_target == '0, "drive target nonzero while tilt shutdown latched")
   `TDTC_ASSERT_NEXT(a_div_len, clock, reset, state_ff == S_DIV && cnt_ff == 3'd7, state_ff == S_FIN, "divider did not finish after eight steps")
   `TDTC_ASSERT_NEXT(a_take_busy, clock, reset, in_xfer, state_ff == S_PREP && !req_ready, "accepted check did not start the sequencer")
   `TDTC_ASSERT_NOW(a_quo_range, clock, reset, state_ff == S_FIN && in_power_ff && th_branch == TH_DERATE, quo_ff <= mode_max, "derate quotient exceeds the mode maximum")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tdtc_pkg::*;

   localparam int RUN_LIMIT       = 500000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PRESSURE_CYCLES = 400;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASE_ITEMS     = 175;

   // Thermal and tilt rule constants, in 1/16 degree and ms
   localparam int          HYST_BAND   = 32;
   localparam int          LEVEL_FLOOR = 20;
   localparam int          FACTOR_DIV  = 20;
   localparam logic [31:0] TRIP_MS     = 32'd2000;

   typedef struct {
      logic [TIME_W-1:0]        time_ms;
      logic signed [TEMP_W-1:0] temperature;
      logic                     power_on;
      logic                     power_saving;
      logic signed [TILT_W-1:0] tilt_x;
      logic signed [TILT_W-1:0] tilt_y;
   } safety_check_type;

   typedef struct {
      logic [PWM_W-1:0] drive_target;
      logic             tilt_tripped;
   } drive_result_type;

   typedef struct {
      logic signed [TEMP_W-1:0] cut_temp;
      logic signed [TEMP_W-1:0] temp_crit;
      logic [PWM_W-1:0]         pwm_normal;
      logic [PWM_W-1:0]         pwm_saving;
      logic [LIM_W-1:0]         lim_fwd;
      logic [LIM_W-1:0]         lim_back;
      logic [LIM_W-1:0]         lim_right;
      logic [LIM_W-1:0]         lim_left;
   } safety_limits_type;

   // Predicts drive target and trip latch per check, holds the results still owed
   class derate_scoreboard;
      safety_limits_type lim;
      logic [PWM_W-1:0]  drive_level;
      logic              trip_latched;
      logic              tilt_timing_on;
      logic [31:0]       tilt_start_ms;
      drive_result_type  expected_drive_q[$];
      int                mismatches;

      function new();
         lim = '{cut_temp: 1280, temp_crit: 1120, pwm_normal: 255, pwm_saving: 128,
                 lim_fwd: 480, lim_back: 480, lim_right: 480, lim_left: 480};
         drive_level    = '0;
         trip_latched   = 1'b0;
         tilt_timing_on = 1'b0;
         tilt_start_ms  = '0;
         mismatches     = 0;
      endfunction

      function void write_limit(reg_idx_type idx, logic [CSR_W-1:0] value);
         case (idx)
            REG_TEMP_MAX:      lim.cut_temp   = value;
            REG_TEMP_CRIT:     lim.temp_crit  = value;
            REG_PWM_NORMAL:    lim.pwm_normal = value[PWM_W-1:0];
            REG_PWM_SAVING:    lim.pwm_saving = value[PWM_W-1:0];
            REG_TILT_FORWARD:  lim.lim_fwd    = value[LIM_W-1:0];
            REG_TILT_BACKWARD: lim.lim_back   = value[LIM_W-1:0];
            REG_TILT_RIGHT:    lim.lim_right  = value[LIM_W-1:0];
            REG_TILT_LEFT:     lim.lim_left   = value[LIM_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_drive_q.size();
      endfunction

      // Advance the rule state by one accepted check and queue its result
      function void note_check(safety_check_type c);
         int               temp, tmax, tcrit, tx, ty, span, margin, level, mode_max;
         bit               run_tilt, tilted;
         logic [31:0]      elapsed;
         drive_result_type r;
         temp     = c.temperature;
         tmax     = lim.cut_temp;
         tcrit    = lim.temp_crit;
         tx       = c.tilt_x;
         ty       = c.tilt_y;
         mode_max = c.power_saving ? int'(lim.pwm_saving) : int'(lim.pwm_normal);
         run_tilt = 1'b1;
         if (c.power_on) begin
            // thermal: cut, derate, recover or hold
            if (temp >= tmax) begin
               drive_level = '0;
               run_tilt    = 1'b0;
            end else if (temp > tcrit) begin
               span   = tmax - tcrit;
               margin = tmax - temp;
               if (FACTOR_DIV * margin < span) level = mode_max / FACTOR_DIV;
               else level = (mode_max * margin) / span;
               if (level < LEVEL_FLOOR) level = LEVEL_FLOOR;
               drive_level = level[PWM_W-1:0];
            end else if (temp < tcrit - HYST_BAND) begin
               drive_level = mode_max[PWM_W-1:0];
            end
            if (trip_latched) drive_level = '0;

            // tilt: time the excursion, latch on timeout, release when level
            if (run_tilt) begin
               tilted = (tx > int'(lim.lim_fwd)) || (tx < -int'(lim.lim_back)) ||
                        (ty > int'(lim.lim_right)) || (ty < -int'(lim.lim_left));
               if (tilted && !trip_latched) begin
                  if (!tilt_timing_on) begin
                     tilt_start_ms  = c.time_ms;
                     tilt_timing_on = 1'b1;
                  end
                  elapsed = c.time_ms - tilt_start_ms;
                  if (elapsed >= TRIP_MS) begin
                     trip_latched = 1'b1;
                     drive_level  = '0;
                  end
               end else if (!tilted) begin
                  tilt_timing_on = 1'b0;
                  if (trip_latched) begin
                     trip_latched = 1'b0;
                     if (temp < tcrit) drive_level = mode_max[PWM_W-1:0];
                  end
               end
            end
         end
         r.drive_target = drive_level;
         r.tilt_tripped = trip_latched;
         expected_drive_q.push_back(r);
      endfunction

      function void check_result(drive_result_type got);
         drive_result_type want;
         if (expected_drive_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: drive_target %0d tilt_tripped %0b",
                        got.drive_target, got.tilt_tripped);
            return;
         end
         want = expected_drive_q.pop_front();
         if (got.drive_target !== want.drive_target ||
             got.tilt_tripped !== want.tilt_tripped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: expected drive_target %0d tilt_tripped %0b, got %0d %0b",
                        want.drive_target, want.tilt_tripped,
                        got.drive_target, got.tilt_tripped);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [TIME_W-1:0]        req_time_ms;
   logic signed [TEMP_W-1:0] req_temperature;
   logic                     req_power_on;
   logic                     req_power_saving;
   logic signed [TILT_W-1:0] req_tilt_x;
   logic signed [TILT_W-1:0] req_tilt_y;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [PWM_W-1:0]         rsp_drive_target;
   logic                     rsp_tilt_tripped;
   logic                     csr_we;
   logic [IDX_W-1:0]         csr_index;
   logic [CSR_W-1:0]         csr_wdata;

   derate_scoreboard drive_sb = new();

   int          cycle_count    = 0;
   int          sender_idle_pct = 0;
   int          rsp_stall_pct  = 0;
   int          hold_len       = 0;
   int          hold_count     = 0;
   logic [31:0] now_ms         = '0;
   int          tilt_run_left  = 0;
   bit          tilt_run_on    = 1'b0;

   thermal_derate_tilt_cutoff dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_time_ms      (req_time_ms),
      .req_temperature  (req_temperature),
      .req_power_on     (req_power_on),
      .req_power_saving (req_power_saving),
      .req_tilt_x       (req_tilt_x),
      .req_tilt_y       (req_tilt_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_target (rsp_drive_target),
      .rsp_tilt_tripped (rsp_tilt_tripped),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("thermal_derate_tilt_cutoff test failed");
         $finish;
      end
   end

   // Receiver: long hold-off first when armed, otherwise random stalls
   always @(posedge clock) begin
      if (hold_count < hold_len) begin
         hold_count <= hold_count + 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watch both channels; check the result before noting a same-cycle input
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            drive_sb.check_result(drive_result_type'{drive_target: rsp_drive_target,
                                                     tilt_tripped: rsp_tilt_tripped});
         if (req_valid && req_ready)
            drive_sb.note_check(safety_check_type'{time_ms: req_time_ms,
                                                   temperature: req_temperature,
                                                   power_on: req_power_on,
                                                   power_saving: req_power_saving,
                                                   tilt_x: req_tilt_x,
                                                   tilt_y: req_tilt_y});
      end
   end

   function automatic safety_check_type mk_check(logic [31:0] t, int temp, bit pon, bit psave,
                                                 int tx, int ty);
      safety_check_type c;
      c.time_ms      = t;
      c.temperature  = temp[TEMP_W-1:0];
      c.power_on     = pon;
      c.power_saving = psave;
      c.tilt_x       = tx[TILT_W-1:0];
      c.tilt_y       = ty[TILT_W-1:0];
      return c;
   endfunction

   // Offer one check after a random gap and hold it until the transfer
   task automatic send_check(input safety_check_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_time_ms      <= c.time_ms;
      req_temperature  <= c.temperature;
      req_power_on     <= c.power_on;
      req_power_saving <= c.power_saving;
      req_tilt_x       <= c.tilt_x;
      req_tilt_y       <= c.tilt_y;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input reg_idx_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
      drive_sb.write_limit(idx, value[CSR_W-1:0]);
   endtask

   task automatic program_limits(input safety_limits_type l);
      write_csr(REG_TEMP_MAX, int'(l.cut_temp));
      write_csr(REG_TEMP_CRIT, int'(l.temp_crit));
      write_csr(REG_PWM_NORMAL, int'(l.pwm_normal));
      write_csr(REG_PWM_SAVING, int'(l.pwm_saving));
      write_csr(REG_TILT_FORWARD, int'(l.lim_fwd));
      write_csr(REG_TILT_BACKWARD, int'(l.lim_back));
      write_csr(REG_TILT_RIGHT, int'(l.lim_right));
      write_csr(REG_TILT_LEFT, int'(l.lim_left));
      csr_we <= 1'b0;
   endtask

   // Drop valid and wait until every owed result is in, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (drive_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic safety_limits_type random_limits();
      safety_limits_type l;
      int tcrit, tmax, swap;
      tcrit = int'($urandom_range(5943)) - 2048;
      tmax  = tcrit + 1 + int'($urandom_range(399));
      if (tmax > 4095) tmax = 4095;
      if ($urandom_range(5) == 0) begin
         swap  = tmax;
         tmax  = tcrit;
         tcrit = swap;
      end
      l.cut_temp   = tmax[TEMP_W-1:0];
      l.temp_crit  = tcrit[TEMP_W-1:0];
      l.pwm_normal = PWM_W'($urandom_range(255));
      l.pwm_saving = PWM_W'(($urandom_range(3) == 0) ? $urandom_range(19)
                                                     : $urandom_range(255));
      l.lim_fwd    = LIM_W'(($urandom_range(3) == 0) ? $urandom_range(2880)
                                                     : $urandom_range(1000, 200));
      l.lim_back   = LIM_W'(($urandom_range(3) == 0) ? $urandom_range(2880)
                                                     : $urandom_range(1000, 200));
      l.lim_right  = LIM_W'(($urandom_range(3) == 0) ? $urandom_range(2880)
                                                     : $urandom_range(1000, 200));
      l.lim_left   = LIM_W'(($urandom_range(3) == 0) ? $urandom_range(2880)
                                                     : $urandom_range(1000, 200));
      return l;
   endfunction

   // Temperatures clustered around the configured thresholds, plus some drawn from the whole range
   function automatic int random_temperature();
      int tmax, tcrit, t;
      tmax  = drive_sb.lim.cut_temp;
      tcrit = drive_sb.lim.temp_crit;
      case ($urandom_range(5))
         0: t = tmax + int'($urandom_range(8)) - 4;
         1: begin
            if (tmax > tcrit) t = tcrit + 1 + int'($urandom_range(tmax - tcrit - 1));
            else t = tcrit + int'($urandom_range(4)) - 2;
         end
         2: t = tcrit - 34 + int'($urandom_range(36));
         3: t = tcrit - 33 - int'($urandom_range(300));
         default: t = int'($urandom_range(6143)) - 2048;
      endcase
      if (t < -2048) t = -2048;
      if (t > 4095) t = 4095;
      return t;
   endfunction

   function automatic int past_limit(int limit);
      int v;
      v = limit + 1 + int'($urandom_range(63));
      return (v > 2880) ? 2880 : v;
   endfunction

   function automatic int level_axis(int pos_lim, int neg_lim);
      case ($urandom_range(7))
         0: return pos_lim;
         1: return -neg_lim;
         default: return int'($urandom_range(pos_lim + neg_lim)) - neg_lim;
      endcase
   endfunction

   // Runs of tilted and level checks with advancing time, plus some noise
   function automatic safety_check_type random_check();
      int tx, ty, fwd, back, right, left;
      fwd   = drive_sb.lim.lim_fwd;
      back  = drive_sb.lim.lim_back;
      right = drive_sb.lim.lim_right;
      left  = drive_sb.lim.lim_left;
      case ($urandom_range(19))
         0: now_ms = $urandom();
         1: ;
         default: now_ms = now_ms + $urandom_range(700, 1);
      endcase
      if (tilt_run_left == 0) begin
         tilt_run_on   = ($urandom_range(2) == 0);
         tilt_run_left = $urandom_range(12, 1);
      end
      tilt_run_left--;
      tx = level_axis(fwd, back);
      ty = level_axis(right, left);
      if (tilt_run_on) begin
         case ($urandom_range(3))
            0: tx = past_limit(fwd);
            1: tx = -past_limit(back);
            2: ty = past_limit(right);
            default: ty = -past_limit(left);
         endcase
      end
      if ($urandom_range(19) == 0) begin
         tx = int'($urandom_range(5760)) - 2880;
         ty = int'($urandom_range(5760)) - 2880;
      end
      return mk_check(now_ms, random_temperature(), $urandom_range(9) != 0,
                      $urandom_range(1) == 1, tx, ty);
   endfunction

   task automatic random_phase(input int n, input int send_pct, input int stall_pct);
      sender_idle_pct = send_pct;
      rsp_stall_pct  <= stall_pct;
      now_ms          = $urandom();
      repeat (n) send_check(random_check());
      drain();
   endtask

   initial begin
      safety_limits_type l;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_time_ms      <= '0;
      req_temperature  <= '0;
      req_power_on     <= 1'b0;
      req_power_saving <= 1'b0;
      req_tilt_x       <= '0;
      req_tilt_y       <= '0;
      csr_we           <= 1'b0;
      csr_index        <= REG_TEMP_MAX;
      csr_wdata        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed checks against the reset limits
      send_check(mk_check(32'd0, 4095, 0, 0, 2880, -2880));    // unpowered, nothing moves
      send_check(mk_check(32'd10, 0, 1, 0, 0, 0));             // recover to normal max
      send_check(mk_check(32'd20, 1120, 1, 1, 0, 0));          // top of hysteresis band
      send_check(mk_check(32'd30, 1088, 1, 1, 0, 0));          // bottom of hysteresis band
      send_check(mk_check(32'd40, 1087, 1, 1, 0, 0));          // just below, saving max
      send_check(mk_check(32'd50, 1121, 1, 0, 0, 0));          // start of derate band
      send_check(mk_check(32'd60, 1273, 1, 0, 0, 0));          // factor clamp and floor
      send_check(mk_check(32'd70, 1279, 1, 1, 0, 0));          // factor clamp and floor, saving max
      send_check(mk_check(32'd80, 1280, 1, 0, 600, 0));        // cut, tilt skipped
      send_check(mk_check(32'd90, 4095, 1, 0, 0, 0));
      send_check(mk_check(32'd100, -2048, 1, 0, 0, 0));
      send_check(mk_check(32'd1000, 0, 1, 0, 481, 0));         // tilt timing starts
      send_check(mk_check(32'd2999, 0, 1, 0, 0, 481));         // one ms short
      send_check(mk_check(32'd3000, 0, 1, 0, -481, 0));        // timeout, latch
      send_check(mk_check(32'd5000, -2048, 1, 0, 0, -2880));   // tilted while latched
      send_check(mk_check(32'd5100, 1120, 1, 0, 480, -480));   // release, target stays 0
      send_check(mk_check(32'd5200, 1000, 1, 0, -480, 480));   // thermal raises it again
      send_check(mk_check(32'hFFFF_FF00, 100, 1, 0, 0, -481)); // timing across the wrap
      send_check(mk_check(32'h0000_0700, 100, 1, 0, 0, -481));
      send_check(mk_check(32'h0000_0800, 0, 0, 0, 0, 0));      // unpowered while latched
      send_check(mk_check(32'h0000_0900, 0, 1, 1, 0, 0));      // release, restore saving max
      send_check(mk_check(32'h0000_0A00, 1280, 1, 0, 2880, 0));
      send_check(mk_check(32'h0000_0B00, 0, 1, 0, 2880, 0));
      send_check(mk_check(32'h0000_2000, 1200, 1, 0, 0, 2880)); // latch inside derate band
      drain();

      // Full backlog: long receiver hold-off with the sender never idle
      program_limits(random_limits());
      hold_len <= hold_len + PRESSURE_CYCLES;
      random_phase(PHASE_ITEMS, 0, 0);

      // Widest derate span, extreme drive levels, zero tilt margin
      l = '{cut_temp: 4095, temp_crit: -2048, pwm_normal: 255, pwm_saving: 0,
            lim_fwd: 0, lim_back: 0, lim_right: 0, lim_left: 0};
      program_limits(l);
      random_phase(PHASE_ITEMS, 62, 0);

      // Equal thermal limits, full tilt range
      l = '{cut_temp: 4095, temp_crit: 4095, pwm_normal: 0, pwm_saving: 255,
            lim_fwd: 2880, lim_back: 2880, lim_right: 2880, lim_left: 2880};
      program_limits(l);
      random_phase(PHASE_ITEMS, 0, 62);

      // One-unit derate band, drive below the floor, lopsided tilt limits
      l = '{cut_temp: 1000, temp_crit: 999, pwm_normal: 19, pwm_saving: 255,
            lim_fwd: 2880, lim_back: 0, lim_right: 1, lim_left: 2880};
      program_limits(l);
      random_phase(PHASE_ITEMS, 35, 35);

      program_limits(random_limits());
      random_phase(PHASE_ITEMS, 0, 0);
      program_limits(random_limits());
      random_phase(PHASE_ITEMS, 62, 0);
      program_limits(random_limits());
      random_phase(PHASE_ITEMS, 0, 62);

      l = '{cut_temp: 1280, temp_crit: 1120, pwm_normal: 255, pwm_saving: 128,
            lim_fwd: 480, lim_back: 480, lim_right: 480, lim_left: 480};
      program_limits(l);
      random_phase(PHASE_ITEMS, 35, 35);

      if (drive_sb.pending() != 0)
         $display("%0d expected results never arrived", drive_sb.pending());
      if (drive_sb.mismatches == 0 && drive_sb.pending() == 0) begin
         $display("thermal_derate_tilt_cutoff test passed");
      end else begin
         $display("thermal_derate_tilt_cutoff test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/tdtc_pkg.sv
sv/thermal_derate_tilt_cutoff.sv
test/testbench.sv
